// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Concurrent check that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/qir_pkg.sv =====
package qir_pkg;

    // Default geometry of the queue.
    localparam int DEPTH_DEF     = 16;
    localparam int MSG_WIDTH_DEF = 32;

    // Width of the action code carried on tuser.
    localparam int ACTION_W = 2;

    // Action codes.
    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH  = 2'd0,
        ACT_POP   = 2'd1,
        ACT_PICK  = 2'd2,
        ACT_QUERY = 2'd3
    } t_action;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

endpackage

// ===== hdl/queue_with_indexed_removal_unit.sv =====
// Path: an action passes through the input register, then the result
// register, which holds its result while the result transfer is stalled.
// Throughput: one action per cycle while the result is not stalled; the
// shifting register array appends, pops or closes a gap in one update.
// Reset: synchronous, active low; the queue is emptied and the valid
// flags of both stages are cleared. Stored message words are not reset.
module queue_with_indexed_removal_unit #(
    parameter int DEPTH     = qir_pkg::DEPTH_DEF,
    parameter int MSG_WIDTH = qir_pkg::MSG_WIDTH_DEF,
    parameter int POS_W     = $clog2(DEPTH),
    parameter int CNT_W     = $clog2(DEPTH + 1),
    parameter int IN_W      = ((MSG_WIDTH + POS_W + 7) / 8) * 8,
    parameter int OUT_W     = ((MSG_WIDTH + 2 + CNT_W + 1 + 7) / 8) * 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // Fields from bit 0: message, position, zero padding.
    input  logic [IN_W-1:0]             i_s_axis_tdata,
    // Fields from bit 0: action.
    input  logic [qir_pkg::ACTION_W-1:0] i_s_axis_tuser,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // Fields from bit 0: removed_message, status, entry_count, is_empty,
    // zero padding.
    output logic [OUT_W-1:0]            o_m_axis_tdata
);

    logic                 r_in_valid;
    qir_pkg::t_action     r_in_action;
    logic [MSG_WIDTH-1:0] r_in_message;
    logic [POS_W-1:0]     r_in_position;

    logic                 r_out_valid;
    logic [MSG_WIDTH-1:0] r_out_removed;
    qir_pkg::t_status     r_out_status;
    logic [CNT_W-1:0]     r_out_count;
    logic                 r_out_empty;

    logic                 out_free;
    logic                 step;
    logic [MSG_WIDTH-1:0] removed;
    qir_pkg::t_status     status;
    logic [CNT_W-1:0]     count;

    // Stage control: the result register frees up when it is empty or its
    // transfer completes; the input register moves on whenever it can.
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign step            = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_action   <= qir_pkg::t_action'(i_s_axis_tuser);
            r_in_message  <= i_s_axis_tdata[MSG_WIDTH-1:0];
            r_in_position <= i_s_axis_tdata[MSG_WIDTH +: POS_W];
        end
    end

    // Queue storage and action logic.
    qir_store #(
        .DEPTH     (DEPTH),
        .MSG_WIDTH (MSG_WIDTH),
        .POS_W     (POS_W),
        .CNT_W     (CNT_W)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (step),
        .i_action   (r_in_action),
        .i_message  (r_in_message),
        .i_position (r_in_position),
        .o_removed  (removed),
        .o_status   (status),
        .o_count    (count)
    );

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_removed <= removed;
            r_out_status  <= status;
            r_out_count   <= count;
            r_out_empty   <= (count == '0);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'({r_out_empty, r_out_count, r_out_status, r_out_removed});

endmodule

// ===== hdl/qir_store.sv =====
module qir_store #(
    parameter int DEPTH     = qir_pkg::DEPTH_DEF,
    parameter int MSG_WIDTH = qir_pkg::MSG_WIDTH_DEF,
    parameter int POS_W     = $clog2(DEPTH),
    parameter int CNT_W     = $clog2(DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  qir_pkg::t_action     i_action,
    input  logic [MSG_WIDTH-1:0] i_message,
    input  logic [POS_W-1:0]     i_position,
    output logic [MSG_WIDTH-1:0] o_removed,
    output qir_pkg::t_status     o_status,
    output logic [CNT_W-1:0]     o_count
);

    logic [MSG_WIDTH-1:0] r_entry [DEPTH];
    logic [MSG_WIDTH-1:0] n_entry [DEPTH];
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 is_full;
    logic                 is_empty;
    logic                 pos_in_range;
    logic                 take;
    logic                 push_ok;
    logic [POS_W-1:0]     idx;
    logic [POS_W-1:0]     tail;

    // Fill state decode.
    assign is_full      = (r_count == CNT_W'(DEPTH));
    assign is_empty     = (r_count == '0);
    assign pos_in_range = (CNT_W'(i_position) < r_count);
    assign idx          = (i_action == qir_pkg::ACT_PICK) ? i_position : '0;
    assign tail         = r_count[POS_W-1:0];

    // Decide what the action does and what it reports.
    always_comb begin
        take     = 1'b0;
        push_ok  = 1'b0;
        o_status = qir_pkg::ST_OK;
        case (i_action)
            qir_pkg::ACT_PUSH: begin
                if (is_full) begin
                    o_status = qir_pkg::ST_FULL;
                end else begin
                    push_ok = 1'b1;
                end
            end
            qir_pkg::ACT_POP: begin
                if (is_empty) begin
                    o_status = qir_pkg::ST_EMPTY;
                end else begin
                    take = 1'b1;
                end
            end
            qir_pkg::ACT_PICK: begin
                if (is_empty) begin
                    o_status = qir_pkg::ST_EMPTY;
                end else if (!pos_in_range) begin
                    o_status = qir_pkg::ST_RANGE;
                end else begin
                    take = 1'b1;
                end
            end
            default: begin
                o_status = qir_pkg::ST_OK;
            end
        endcase
    end

    // The removed entry is read before the gap is closed.
    assign o_removed = take ? r_entry[idx] : '0;

    // Count after the action.
    always_comb begin
        n_count = r_count;
        if (push_ok) begin
            n_count = r_count + CNT_W'(1);
        end else if (take) begin
            n_count = r_count - CNT_W'(1);
        end
    end
    assign o_count = n_count;

    // Each slot either keeps its word, takes its neighbor's word when the gap
    // closes, or takes the pushed message when it is the tail slot.
    for (genvar k = 0; k < DEPTH; k++) begin : g_slot
        if (k < DEPTH - 1) begin : g_shift
            always_comb begin
                n_entry[k] = r_entry[k];
                if (take && (POS_W'(k) >= idx)) begin
                    n_entry[k] = r_entry[k+1];
                end
                if (push_ok && (tail == POS_W'(k))) begin
                    n_entry[k] = i_message;
                end
            end
        end else begin : g_last
            always_comb begin
                n_entry[k] = r_entry[k];
                if (push_ok && (tail == POS_W'(k))) begin
                    n_entry[k] = i_message;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_entry[k] <= n_entry[k];
            end
        end
    end

    // Occupancy register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_en) begin
            r_count <= n_count;
        end
    end

endmodule

// ===== hdl/qir_checker.sv =====
`include "assert_macros.svh"

module qir_checker #(
    parameter int DEPTH     = qir_pkg::DEPTH_DEF,
    parameter int MSG_WIDTH = qir_pkg::MSG_WIDTH_DEF,
    parameter int CNT_W     = $clog2(DEPTH + 1),
    parameter int OUT_W     = ((MSG_WIDTH + 2 + CNT_W + 1 + 7) / 8) * 8
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_m_axis_tvalid,
    input logic             i_m_axis_tready,
    input logic [OUT_W-1:0] o_m_axis_tdata
);

    localparam int ST_LO  = MSG_WIDTH;
    localparam int CNT_LO = MSG_WIDTH + 2;
    localparam int EMP_B  = MSG_WIDTH + 2 + CNT_W;

    logic [MSG_WIDTH-1:0] removed;
    logic [1:0]           status;
    logic [CNT_W-1:0]     count;
    logic                 empty;

    assign removed = o_m_axis_tdata[MSG_WIDTH-1:0];
    assign status  = o_m_axis_tdata[ST_LO +: 2];
    assign count   = o_m_axis_tdata[CNT_LO +: CNT_W];
    assign empty   = o_m_axis_tdata[EMP_B];

    // No result is offered in the cycle after reset.
    `ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "result valid after reset")

    // A stalled result holds.
    `ASSERT_CLK(a_stall_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled result changed")

    // The empty flag agrees with the count.
    `ASSERT_CLK(a_empty_match, i_clk, i_rst_n, o_m_axis_tvalid |-> (empty == (count == '0)), "empty flag disagrees with count")

    // A failed action removes nothing.
    `ASSERT_CLK(a_fail_no_msg, i_clk, i_rst_n, o_m_axis_tvalid && (status != qir_pkg::ST_OK) |-> (removed == '0), "message returned on failed action")

    // A full report means the queue holds DEPTH entries.
    `ASSERT_CLK(a_full_count, i_clk, i_rst_n, o_m_axis_tvalid && (status == qir_pkg::ST_FULL) |-> (count == CNT_W'(DEPTH)), "full status with short queue")

endmodule

bind queue_with_indexed_removal_unit qir_checker #(
    .DEPTH     (DEPTH),
    .MSG_WIDTH (MSG_WIDTH),
    .CNT_W     (CNT_W),
    .OUT_W     (OUT_W)
) u_qir_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
